// ===== hw/rtl/rdc_pkg.sv =====
// Shared constants and types of the rotor density convolver.
package rdc_pkg;

	localparam int MAX_TAPS  = 256;
	localparam int TAP_W     = $clog2(MAX_TAPS + 1);
	localparam int HIDX_W    = $clog2(MAX_TAPS);
	localparam int BIN_W     = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_W     = 32;

	localparam logic [CFG_IDX_W-1:0] CFG_ROTOR_TYPE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_INV_SYM    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_GAP        = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_ANG_MOM    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_BIN_WIDTH  = 3'd4;

	localparam logic [1:0] ROT_LINEAR    = 2'd0;
	localparam logic [1:0] ROT_SPHERICAL = 2'd1;
	localparam logic [1:0] ROT_PROLATE   = 2'd2;
	localparam logic [1:0] ROT_OBLATE    = 2'd3;

	localparam int ROOT_FRAC = 48;
	localparam int ROOT_W    = ROOT_FRAC / 2 + 1;
	localparam int ROOT_X_W  = ROOT_FRAC + 1;
	localparam int DIV_W     = TAP_W + ROOT_FRAC;
	localparam int DIV_CNT_W = $clog2(DIV_W);

	localparam logic [ROOT_W-1:0] ROOT_ONE = ROOT_W'(1) << (ROOT_FRAC / 2);

	typedef struct packed {
		logic              start;
		logic [TAP_W-1:0]  m;
		logic [TAP_W-1:0]  n;
	} root_req_t;

	typedef struct packed {
		logic              done;
		logic [ROOT_W-1:0] root;
	} root_rsp_t;

endpackage

// ===== hw/rtl/rdc_in_if.sv =====
// Input channel of the rotor density convolver.
interface rdc_in_if import rdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] bin_value;
	logic             final_bin;

	modport source (output valid, output bin_value, output final_bin, input ready);
	modport sink (input valid, input bin_value, input final_bin, output ready);
endinterface

// ===== hw/rtl/rdc_out_if.sv =====
// Output channel of the rotor density convolver.
interface rdc_out_if import rdc_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [BIN_W-1:0] result_value;
	logic             final_out;
	logic             taps_clamped;

	modport source (output valid, output result_value, output final_out,
		output taps_clamped, input ready);
	modport sink (input valid, input result_value, input final_out,
		input taps_clamped, output ready);
endinterface

// ===== hw/rtl/rdc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rdc_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== hw/rtl/rdc_root.sv =====
// Bit-serial unit for floor(sqrt(floor(m * 2^48 / n))).
module rdc_root import rdc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  root_req_t req,
	output root_rsp_t rsp
);
	typedef enum logic [1:0] {R_IDLE, R_DIV, R_SQRT} rstate_t;

	rstate_t              state_q;
	logic [DIV_W-1:0]     div_q;
	logic [TAP_W-1:0]     rem_q;
	logic [TAP_W-1:0]     n_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [ROOT_X_W-1:0]  x_q;
	logic [ROOT_X_W-1:0]  r_q;
	logic [ROOT_X_W-1:0]  bit_q;

	logic [TAP_W:0]      rem_sh;
	logic                ge;
	logic [TAP_W:0]      rem_nx;
	logic [DIV_W-1:0]    div_nx;
	logic [ROOT_X_W:0]   t_sum;
	logic                sq_ge;
	logic [ROOT_X_W-1:0] r_nx;

	assign rem_sh = {rem_q, div_q[DIV_W-1]};
	assign ge     = rem_sh >= {1'b0, n_q};
	assign rem_nx = ge ? rem_sh - {1'b0, n_q} : rem_sh;
	assign div_nx = {div_q[DIV_W-2:0], ge};
	assign t_sum  = {1'b0, r_q} + {1'b0, bit_q};
	assign sq_ge  = {1'b0, x_q} >= t_sum;
	assign r_nx   = sq_ge ? (r_q >> 1) + bit_q : r_q >> 1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= R_IDLE;
			div_q    <= '0;
			rem_q    <= '0;
			n_q      <= '0;
			cnt_q    <= '0;
			x_q      <= '0;
			r_q      <= '0;
			bit_q    <= '0;
			rsp      <= '0;
		end else begin
			rsp.done <= (state_q == R_SQRT) && (bit_q == ROOT_X_W'(1));
			unique case (state_q)
				R_IDLE: begin
					if (req.start) begin
						div_q   <= DIV_W'(req.m) << ROOT_FRAC;
						rem_q   <= '0;
						n_q     <= req.n;
						cnt_q   <= '0;
						state_q <= R_DIV;
					end
				end
				R_DIV: begin
					div_q <= div_nx;
					rem_q <= rem_nx[TAP_W-1:0];
					cnt_q <= cnt_q + DIV_CNT_W'(1);
					if (cnt_q == DIV_CNT_W'(DIV_W - 1)) begin
						x_q     <= div_nx[ROOT_X_W-1:0];
						r_q     <= '0;
						bit_q   <= ROOT_X_W'(1) << ROOT_FRAC;
						state_q <= R_SQRT;
					end
				end
				R_SQRT: begin
					if (sq_ge) begin
						x_q <= x_q - t_sum[ROOT_X_W-1:0];
					end
					r_q   <= r_nx;
					bit_q <= bit_q >> 2;
					if (bit_q == ROOT_X_W'(1)) begin
						rsp.root <= r_nx[ROOT_W-1:0];
						state_q  <= R_IDLE;
					end
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end
endmodule

// ===== hw/rtl/rotor_density_convolver.sv =====
// Top level of the rotor density convolver.
// Takes one profile bin per item on in_ch and returns one convolved bin on out_ch.
// Registers are written through cfg_we / cfg_index / cfg_data; the user must write
// them only while the block is idle, and the block itself does not enforce this.
// Linear rotor: each bin is scaled by 2j/sigma; spherical top: by 4j^2/sigma.
// Prolate and oblate tops: a multiply-accumulate over min(bins seen, taps), one
// tap a cycle through the shared 32x32 multiplier.
// The first item of a job (after reset or after final_bin) for a top type first
// builds the tap table, using the bit-serial divide and square root unit for
// each tap.
// in_ch.ready is high only while the sequencer is idle; one item at a time.
// A finished result waits in the output register while the next item is taken;
// if the receiver stalls, the sequencer holds its next result until it is free.
// Reset clears the registers to their defaults and starts a new job; the tap
// and history RAMs are not cleared, since a job only reads entries it wrote.
module rotor_density_convolver import rdc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	rdc_in_if.sink               in_ch,
	rdc_out_if.source            out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);
	localparam int DCNT_W = $clog2(TAP_W);

	typedef enum logic [4:0] {
		S_IDLE, S_J2, S_A0, S_A1, S_A2, S_A3, S_G0, S_G1, S_G2, S_N, S_DIV, S_NCEIL,
		S_T_ROOT, S_T_WAIT, S_T_M0, S_T_M1, S_T_M2, S_T_WR, S_HIST, S_LIN, S_LIN2,
		S_SC0, S_SC1, S_SC2, S_SC3, S_MAC, S_MAC_END, S_OUT
	} state_t;

	logic [1:0]  rotor_type_q;
	logic [23:0] inv_sym_q;
	logic [31:0] gap_q;
	logic [23:0] ang_q;
	logic [31:0] bw_q;

	state_t              state_q;
	logic [BIN_W-1:0]    bin_q;
	logic                fin_q;
	logic                build_q;
	logic                table_ready_q;
	logic [HIDX_W-1:0]   ptr_q;
	logic [TAP_W-1:0]    seen_q;
	logic [TAP_W-1:0]    tap_count_q;
	logic                clamp_q;
	logic [47:0]         j2_q;
	logic [63:0]         coef_q;
	logic [95:0]         acc_q;
	logic [95:0]         dsh_q;
	logic [DCNT_W-1:0]   cnt_q;
	logic [TAP_W-1:0]    i_q;
	logic [TAP_W-1:0]    n_q;
	logic [ROOT_W-1:0]   qprev_q;
	logic [ROOT_W-1:0]   d_q;
	logic [TAP_W-1:0]    rd_i_q;
	logic                v1_q;
	logic                v2_q;
	logic [BIN_W-1:0]    res_q;
	logic                flg_q;
	logic                out_val_q;
	logic [BIN_W-1:0]    out_res_q;
	logic                out_fin_q;
	logic                out_flg_q;
	logic [63:0]         product_s1;

	logic [31:0]         mul_a;
	logic [31:0]         mul_b;
	logic                prolate;
	logic [95:0]         den96;
	logic [95:0]         lim96;
	logic [63:0]         a_sat;
	logic [64:0]         mac_sum;
	logic [32:0]         mac_v;
	logic [TAP_W-1:0]    terms;
	logic                issue;
	logic [TAP_W-1:0]    ptr_ext;
	logic [TAP_W-1:0]    hidx;
	logic                hist_we;
	logic [HIDX_W-1:0]   hist_raddr;
	logic [BIN_W-1:0]    hist_rdata;
	logic                tap_we;
	logic [BIN_W-1:0]    tap_wdata;
	logic [BIN_W-1:0]    tap_rdata;
	logic                out_free;
	root_req_t           root_req;
	root_rsp_t           root_rsp;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rotor_type_q <= ROT_LINEAR;
			inv_sym_q    <= 24'd65536;
			gap_q        <= '0;
			ang_q        <= '0;
			bw_q         <= 32'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_ROTOR_TYPE: rotor_type_q <= cfg_data[1:0];
				CFG_INV_SYM:    inv_sym_q    <= cfg_data[23:0];
				CFG_GAP:        gap_q        <= cfg_data;
				CFG_ANG_MOM:    ang_q        <= cfg_data[23:0];
				CFG_BIN_WIDTH:  bw_q         <= cfg_data;
				default: ;
			endcase
		end
	end

	// Shared multiplier operands
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_J2: begin
				mul_a = 32'(ang_q);
				mul_b = 32'(ang_q);
			end
			S_A0: begin
				mul_a = product_s1[31:0];
				mul_b = 32'(inv_sym_q);
			end
			S_A1: begin
				mul_a = 32'(j2_q[47:32]);
				mul_b = 32'(inv_sym_q);
			end
			S_G0: begin
				mul_a = gap_q;
				mul_b = j2_q[31:0];
			end
			S_G1: begin
				mul_a = gap_q;
				mul_b = 32'(j2_q[47:32]);
			end
			S_LIN: begin
				mul_a = 32'(ang_q);
				mul_b = 32'(inv_sym_q);
			end
			S_T_M0: begin
				mul_a = coef_q[31:0];
				mul_b = 32'(d_q);
			end
			S_T_M1: begin
				mul_a = coef_q[63:32];
				mul_b = 32'(d_q);
			end
			S_SC0: begin
				mul_a = coef_q[31:0];
				mul_b = bin_q;
			end
			S_SC1: begin
				mul_a = coef_q[63:32];
				mul_b = bin_q;
			end
			S_MAC: begin
				mul_a = hist_rdata;
				mul_b = tap_rdata;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		product_s1 <= mul_a * mul_b;
	end

	assign prolate = rotor_type_q == ROT_PROLATE;
	assign den96   = 96'(bw_q) << 16;
	assign lim96   = den96 * 96'(MAX_TAPS);
	assign a_sat   = (|acc_q[95:62]) ? '1 : {acc_q[61:0], 2'b00};
	assign mac_sum = 65'(acc_q[63:0]) + 65'(product_s1);
	assign mac_v   = 33'(acc_q[63:32]) + 33'(acc_q[31]);
	assign terms   = (seen_q < tap_count_q) ? seen_q : tap_count_q;
	assign issue   = (state_q == S_MAC) && (rd_i_q < terms);
	assign ptr_ext = TAP_W'(ptr_q);
	assign hidx    = (ptr_ext >= rd_i_q) ? ptr_ext - rd_i_q
	                                     : ptr_ext + TAP_W'(MAX_TAPS) - rd_i_q;
	assign hist_raddr = hidx[HIDX_W-1:0];
	assign hist_we    = state_q == S_HIST;
	assign tap_we     = state_q == S_T_WR;
	assign tap_wdata  = (|acc_q[95:72]) ? '1 : acc_q[71:40];
	assign out_free   = !out_val_q || out_ch.ready;

	assign root_req.start = state_q == S_T_ROOT;
	assign root_req.m     = prolate ? i_q + TAP_W'(1) : n_q - i_q - TAP_W'(1);
	assign root_req.n     = n_q;

	rdc_ram #(.WIDTH(BIN_W), .DEPTH(MAX_TAPS)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (ptr_q),
		.wdata (bin_q),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	rdc_ram #(.WIDTH(BIN_W), .DEPTH(MAX_TAPS)) u_tap_ram (
		.clk   (clk),
		.we    (tap_we),
		.waddr (i_q[HIDX_W-1:0]),
		.wdata (tap_wdata),
		.raddr (rd_i_q[HIDX_W-1:0]),
		.rdata (tap_rdata)
	);

	rdc_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (root_req),
		.rsp    (root_rsp)
	);

	assign in_ch.ready         = state_q == S_IDLE;
	assign out_ch.valid        = out_val_q;
	assign out_ch.result_value = out_res_q;
	assign out_ch.final_out    = out_fin_q;
	assign out_ch.taps_clamped = out_flg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			bin_q         <= '0;
			fin_q         <= 1'b0;
			build_q       <= 1'b0;
			table_ready_q <= 1'b0;
			ptr_q         <= '0;
			seen_q        <= '0;
			tap_count_q   <= '0;
			clamp_q       <= 1'b0;
			j2_q          <= '0;
			coef_q        <= '0;
			acc_q         <= '0;
			dsh_q         <= '0;
			cnt_q         <= '0;
			i_q           <= '0;
			n_q           <= '0;
			qprev_q       <= '0;
			d_q           <= '0;
			rd_i_q        <= '0;
			v1_q          <= 1'b0;
			v2_q          <= 1'b0;
			res_q         <= '0;
			flg_q         <= 1'b0;
			out_val_q     <= 1'b0;
			out_res_q     <= '0;
			out_fin_q     <= 1'b0;
			out_flg_q     <= 1'b0;
		end else begin
			if (state_q == S_OUT && out_free) begin
				out_val_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_val_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_ch.valid) begin
						bin_q <= in_ch.bin_value;
						fin_q <= in_ch.final_bin;
						state_q <= S_HIST;
						if (!table_ready_q) begin
							table_ready_q <= 1'b1;
							ptr_q         <= '0;
							seen_q        <= '0;
							tap_count_q   <= '0;
							clamp_q       <= 1'b0;
							if (rotor_type_q >= ROT_PROLATE) begin
								build_q <= 1'b1;
								state_q <= S_J2;
							end
						end
					end
				end
				S_J2: state_q <= S_A0;
				S_A0: begin
					j2_q    <= product_s1[47:0];
					state_q <= S_A1;
				end
				S_A1: begin
					acc_q   <= 96'(product_s1);
					state_q <= S_A2;
				end
				S_A2: begin
					acc_q   <= acc_q + {product_s1, 32'b0};
					state_q <= S_A3;
				end
				S_A3: begin
					coef_q  <= a_sat;
					state_q <= build_q ? S_G0 : S_SC0;
				end
				S_G0: state_q <= S_G1;
				S_G1: begin
					acc_q   <= 96'(product_s1);
					state_q <= S_G2;
				end
				S_G2: begin
					acc_q   <= acc_q + {product_s1, 32'b0};
					state_q <= S_N;
				end
				S_N: begin
					build_q <= 1'b0;
					if (acc_q == '0) begin
						state_q <= S_HIST;
					end else if (bw_q == '0 || acc_q > lim96) begin
						n_q     <= TAP_W'(MAX_TAPS);
						clamp_q <= 1'b1;
						i_q     <= '0;
						qprev_q <= prolate ? '0 : ROOT_ONE;
						state_q <= S_T_ROOT;
					end else begin
						dsh_q   <= den96 << (TAP_W - 1);
						cnt_q   <= DCNT_W'(TAP_W - 1);
						n_q     <= '0;
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					if (acc_q >= dsh_q) begin
						acc_q <= acc_q - dsh_q;
					end
					n_q   <= {n_q[TAP_W-2:0], acc_q >= dsh_q};
					dsh_q <= dsh_q >> 1;
					cnt_q <= cnt_q - DCNT_W'(1);
					if (cnt_q == '0) begin
						state_q <= S_NCEIL;
					end
				end
				S_NCEIL: begin
					n_q     <= n_q + TAP_W'(acc_q != '0);
					i_q     <= '0;
					qprev_q <= prolate ? '0 : ROOT_ONE;
					state_q <= S_T_ROOT;
				end
				S_T_ROOT: state_q <= S_T_WAIT;
				S_T_WAIT: begin
					if (root_rsp.done) begin
						d_q     <= prolate ? root_rsp.root - qprev_q : qprev_q - root_rsp.root;
						qprev_q <= root_rsp.root;
						state_q <= S_T_M0;
					end
				end
				S_T_M0: state_q <= S_T_M1;
				S_T_M1: begin
					acc_q   <= 96'(product_s1) + (96'(1) << 39);
					state_q <= S_T_M2;
				end
				S_T_M2: begin
					acc_q   <= acc_q + {product_s1, 32'b0};
					state_q <= S_T_WR;
				end
				S_T_WR: begin
					i_q <= i_q + TAP_W'(1);
					if (i_q + TAP_W'(1) == n_q) begin
						tap_count_q <= n_q;
						state_q     <= S_HIST;
					end else begin
						state_q <= S_T_ROOT;
					end
				end
				S_HIST: begin
					if (seen_q < TAP_W'(MAX_TAPS)) begin
						seen_q <= seen_q + TAP_W'(1);
					end
					case (rotor_type_q)
						ROT_LINEAR:    state_q <= S_LIN;
						ROT_SPHERICAL: state_q <= S_J2;
						default: begin
							rd_i_q  <= '0;
							v1_q    <= 1'b0;
							v2_q    <= 1'b0;
							acc_q   <= '0;
							state_q <= S_MAC;
						end
					endcase
				end
				S_LIN: state_q <= S_LIN2;
				S_LIN2: begin
					coef_q  <= 64'(product_s1) << 9;
					state_q <= S_SC0;
				end
				S_SC0: state_q <= S_SC1;
				S_SC1: begin
					acc_q   <= 96'(product_s1) + (96'(1) << 31);
					state_q <= S_SC2;
				end
				S_SC2: begin
					acc_q   <= acc_q + {product_s1, 32'b0};
					state_q <= S_SC3;
				end
				S_SC3: begin
					res_q   <= (|acc_q[95:64]) ? '1 : acc_q[63:32];
					flg_q   <= 1'b0;
					state_q <= S_OUT;
				end
				S_MAC: begin
					if (issue) begin
						rd_i_q <= rd_i_q + TAP_W'(1);
					end
					v1_q <= issue;
					v2_q <= v1_q;
					if (v2_q) begin
						acc_q <= {32'b0, mac_sum[64] ? 64'hFFFF_FFFF_FFFF_FFFF : mac_sum[63:0]};
					end
					if (!issue && !v1_q && !v2_q) begin
						state_q <= S_MAC_END;
					end
				end
				S_MAC_END: begin
					res_q   <= mac_v[32] ? '1 : mac_v[31:0];
					flg_q   <= clamp_q;
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) begin
						out_res_q <= res_q;
						out_fin_q <= fin_q;
						out_flg_q <= flg_q;
						ptr_q     <= (ptr_q == HIDX_W'(MAX_TAPS - 1)) ? '0 : ptr_q + HIDX_W'(1);
						if (fin_q) begin
							table_ready_q <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule

// ===== tb/sv/rotor_density_convolver_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the rotor density convolver: directed and random bins.
module rotor_density_convolver_test;
	import rdc_pkg::*;

	localparam int IDLE_LIMIT = 100000;

	typedef struct packed {
		logic [31:0] value;
		logic        fin;
		logic        clamped;
	} conv_bin_t;

	logic clk = 0;
	logic arst_n = 0;
	logic cfg_we = 0;
	logic [CFG_IDX_W-1:0] cfg_index = 0;
	logic [CFG_W-1:0] cfg_data = 0;

	rdc_in_if  in_ch ();
	rdc_out_if out_ch ();

	rotor_density_convolver dut (
		.clk(clk), .arst_n(arst_n), .in_ch(in_ch), .out_ch(out_ch),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	// register copy and convolver state
	logic [1:0]  rotor;
	logic [23:0] inv_sym, jmom;
	logic [31:0] gap, bw;
	logic [31:0] taps [MAX_TAPS];
	logic [31:0] hist [MAX_TAPS];
	int unsigned hptr, seen, ntaps;
	bit          table_ok, clamp_job;

	conv_bin_t expected_bins [$];
	int errors = 0;
	bit calm = 0;
	int long_hold = 0;
	int stall_left = 0;
	int idle_cycles = 0;

	function automatic logic [63:0] isqrt(logic [63:0] x);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic [63:0] root_q(int unsigned m, int unsigned n);
		return isqrt((64'(m) << 48) / 64'(n));
	endfunction

	function automatic logic [63:0] four_coef();
		logic [127:0] pr;
		pr = 128'(64'(jmom) * 64'(jmom)) * 128'(inv_sym);
		if ((pr >> 62) != 0) return '1;
		return pr[63:0] << 2;
	endfunction

	function automatic logic [31:0] scale(logic [63:0] coef, logic [31:0] b);
		logic [127:0] v;
		v = (128'(coef) * 128'(b) + (128'd1 << 31)) >> 32;
		return (v > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
	endfunction

	function automatic void build_taps();
		logic [127:0] num, t;
		logic [63:0] den, a, d;
		int unsigned n;
		a = four_coef();
		den = 64'(bw) << 16;
		ntaps = 0;
		clamp_job = 0;
		if (rotor < ROT_PROLATE) return;
		num = 128'(gap) * 128'(64'(jmom) * 64'(jmom));
		if (num == 0) n = 0;
		else if (den == 0 || num > 128'(den) * MAX_TAPS) begin
			n = MAX_TAPS;
			clamp_job = 1;
		end else n = int'((num + den - 1) / den);
		for (int unsigned i = 0; i < n; i++) begin
			if (rotor == ROT_PROLATE) d = root_q(i + 1, n) - root_q(i, n);
			else d = root_q(n - i, n) - root_q(n - i - 1, n);
			t = (128'(a) * 128'(d) + (128'd1 << 39)) >> 40;
			taps[i] = (t > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : t[31:0];
		end
		ntaps = n;
	endfunction

	function automatic conv_bin_t convolve_bin(logic [31:0] b, logic fin);
		conv_bin_t r;
		logic [63:0] acc;
		logic [64:0] s;
		logic [32:0] v;
		int unsigned terms, idx;
		if (!table_ok) begin
			build_taps();
			hptr = 0;
			seen = 0;
			table_ok = 1;
		end
		hist[hptr] = b;
		if (seen < MAX_TAPS) seen++;
		r.fin = fin;
		r.clamped = 0;
		if (rotor == ROT_LINEAR) r.value = scale((64'(jmom) * 64'(inv_sym)) << 9, b);
		else if (rotor == ROT_SPHERICAL) r.value = scale(four_coef(), b);
		else begin
			terms = (seen < ntaps) ? seen : ntaps;
			acc = 0;
			for (int unsigned i = 0; i < terms; i++) begin
				idx = (hptr >= i) ? hptr - i : hptr + MAX_TAPS - i;
				s = 65'(acc) + 65'(64'(hist[idx]) * 64'(taps[i]));
				acc = s[64] ? '1 : s[63:0];
			end
			v = 33'(acc >> 32) + 33'(acc[31]);
			r.value = v[32] ? 32'hFFFF_FFFF : v[31:0];
			r.clamped = clamp_job;
		end
		hptr = (hptr + 1 >= MAX_TAPS) ? 0 : hptr + 1;
		if (fin) table_ok = 0;
		return r;
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		errors++;
		$display("mismatch %s: got %h, expected %h", what, got, want);
	endtask

	task automatic queue_expected(conv_bin_t item);
		expected_bins = {expected_bins, item};
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= data;
		case (idx)
			CFG_ROTOR_TYPE: rotor = data[1:0];
			CFG_INV_SYM: inv_sym = data[23:0];
			CFG_GAP: gap = data;
			CFG_ANG_MOM: jmom = data[23:0];
			CFG_BIN_WIDTH: bw = data;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic setup(logic [1:0] rt, logic [23:0] inv, logic [31:0] g,
			logic [23:0] j, logic [31:0] w);
		write_reg(CFG_ROTOR_TYPE, 32'(rt));
		write_reg(CFG_INV_SYM, 32'(inv));
		write_reg(CFG_GAP, g);
		write_reg(CFG_ANG_MOM, 32'(j));
		write_reg(CFG_BIN_WIDTH, w);
	endtask

	task automatic send_bin(logic [31:0] b, logic fin);
		if (!calm && $urandom_range(0, 3) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.bin_value <= b;
		in_ch.final_bin <= fin;
		do @(posedge clk); while (!in_ch.ready);
		queue_expected(convolve_bin(b, fin));
	endtask

	task automatic drain();
		in_ch.valid <= 0;
		while (expected_bins.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic run_job(int len);
		for (int i = 0; i < len; i++) send_bin($urandom, i == len - 1);
	endtask

	always @(posedge clk) begin
		conv_bin_t want;
		if (out_ch.valid && out_ch.ready) begin
			if (expected_bins.size() == 0) begin
				report("unexpected item", out_ch.result_value, 32'h0);
			end else begin
				want = expected_bins.pop_front();
				if (out_ch.result_value !== want.value)
					report("result_value", out_ch.result_value, want.value);
				if (out_ch.final_out !== want.fin)
					report("final_out", 32'(out_ch.final_out), 32'(want.fin));
				if (out_ch.taps_clamped !== want.clamped)
					report("taps_clamped", 32'(out_ch.taps_clamped), 32'(want.clamped));
			end
		end
		if (long_hold > 0) begin
			out_ch.ready <= 0;
			long_hold--;
		end else if (stall_left > 0) begin
			out_ch.ready <= 0;
			stall_left--;
		end else if (!calm && $urandom_range(0, 7) == 0) begin
			out_ch.ready <= 0;
			stall_left = $urandom_range(1, 10) - 1;
		end else begin
			out_ch.ready <= 1;
		end
	end

	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles = 0;
		else idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic test_linear();
		setup(ROT_LINEAR, 24'h010000, 0, 24'h000100, 32'h0001_0000);
		send_bin(32'h0, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b0);
		send_bin(32'h1, 1'b0);
		send_bin(32'h8000_0000, 1'b1);
		drain();
		setup(ROT_LINEAR, 24'hFFFFFF, 0, 24'hFFFFFF, 32'h0001_0000);
		send_bin(32'h0000_0001, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b1);
		drain();
		write_reg(CFG_INV_SYM, 32'h0);
		send_bin(32'hFFFF_FFFF, 1'b1);
		drain();
	endtask

	task automatic test_spherical();
		setup(ROT_SPHERICAL, 24'h008000, 0, 24'h000280, 32'h0001_0000);
		run_job(3);
		drain();
		write_reg(CFG_INV_SYM, 32'h00FF_FFFF);
		write_reg(CFG_ANG_MOM, 32'h00FF_FFFF);
		send_bin(32'h0, 1'b0);
		send_bin(32'h1, 1'b1);
		drain();
	endtask

	task automatic test_tops();
		setup(ROT_PROLATE, 24'h010000, 32'h0005_0000, 24'h000100, 32'h0001_0000);
		run_job(10);
		drain();
		write_reg(CFG_ROTOR_TYPE, 32'(ROT_OBLATE));
		run_job(10);
		drain();
		write_reg(CFG_GAP, 32'h0);
		run_job(3);
		drain();
		write_reg(CFG_GAP, 32'h0003_0000);
		write_reg(CFG_ANG_MOM, 32'h0);
		run_job(3);
		drain();
	endtask

	task automatic test_clamp();
		setup(ROT_PROLATE, 24'hFFFFFF, 32'hFFFF_FFFF, 24'h000100, 32'hFFFF_FFFF);
		run_job(3);
		drain();
		setup(ROT_OBLATE, 24'h010000, 32'h0001_0000, 24'h000100, 0);
		send_bin(32'hFFFF_FFFF, 1'b0);
		send_bin(32'hFFFF_FFFF, 1'b1);
		drain();
	endtask

	task automatic test_midjob_switch();
		setup(ROT_LINEAR, 24'h010000, 32'h0004_0000, 24'h000100, 32'h0001_0000);
		send_bin($urandom, 1'b0);
		send_bin($urandom, 1'b0);
		drain();
		write_reg(CFG_ROTOR_TYPE, 32'(ROT_PROLATE));
		send_bin($urandom, 1'b0);
		send_bin($urandom, 1'b1);
		drain();
	endtask

	task automatic test_long_job();
		setup(ROT_PROLATE, 24'h004000, 32'h0006_0000, 24'h000100, 32'h0001_0000);
		for (int i = 0; i < 300; i++) begin
			if (i == 20) long_hold = 400;
			send_bin($urandom, i == 299);
		end
		drain();
	endtask

	task automatic test_random();
		int sent, len;
		sent = 0;
		while (sent < 150) begin
			if (sent > 110) calm = 1;
			if ($urandom_range(0, 19) == 0)
				setup(2'($urandom_range(0, 3)), 24'($urandom), $urandom, 24'($urandom),
					$urandom);
			else
				setup(2'($urandom_range(0, 3)), 24'($urandom),
					32'($urandom_range(0, 4 * 65536)),
					24'(256 * $urandom_range(1, 3)), 32'(65536 * $urandom_range(1, 4)));
			len = $urandom_range(1, 20);
			run_job(len);
			sent += len;
			drain();
		end
	endtask

	initial begin
		in_ch.valid = 0;
		in_ch.bin_value = 0;
		in_ch.final_bin = 0;
		out_ch.ready = 0;
		rotor = ROT_LINEAR;
		inv_sym = 24'h010000;
		gap = 0;
		jmom = 0;
		bw = 32'h0001_0000;
		table_ok = 0;
		hptr = 0;
		seen = 0;
		ntaps = 0;
		clamp_job = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		test_linear();
		test_spherical();
		test_tops();
		test_clamp();
		test_midjob_switch();
		test_long_job();
		test_random();
		repeat (50) @(posedge clk);
		if (errors == 0 && expected_bins.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule
